// ===== rtl/core/lru_page_replacement_core_defines.svh =====
// ---------------------------------------------------------------------------
// lru page replacement core assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LRUPR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru_page_replacement_core: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru_page_replacement_core: next-cycle check failed");

`endif

// ===== rtl/core/lrupr_pkg.sv =====
// ---------------------------------------------------------------------------
// lrupr_pkg
// shared constants, token and update types, controller states
// ---------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

	localparam int FRAMES_DEF    = 8;
	localparam int FRAMES_MAX    = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int PAGE_BITS_MAX = 32;

	// index and rank fields sized for the largest frame count
	localparam int IDX_W       = 4;
	localparam int PAGE_W      = 16;
	localparam int FRAME_IDX_W = 3;
	localparam int FAULT_W     = 32;
	localparam int CFG_W       = 4;

	localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

	// search request walking down the cell row
	typedef struct packed {
		logic                     vld;
		logic [PAGE_BITS_MAX-1:0] page;
		logic                     hit;
		logic [IDX_W-1:0]         hit_idx;
		logic [IDX_W-1:0]         hit_rank;
		logic                     empty;
		logic [IDX_W-1:0]         empty_idx;
		logic [IDX_W-1:0]         vic_idx;
		logic [IDX_W-1:0]         vic_rank;
		logic [PAGE_BITS_MAX-1:0] vic_page;
	} tok_t;

	// broadcast that makes one frame most recently used
	typedef struct packed {
		logic                     vld;
		logic [IDX_W-1:0]         slot;
		logic                     was_valid;
		logic [IDX_W-1:0]         old_rank;
		logic                     fill;
		logic [PAGE_BITS_MAX-1:0] page;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrupr_cell.sv =====
// ---------------------------------------------------------------------------
// lrupr_cell
// one page frame: holds page, valid and recency rank, merges itself into
// the passing search request and registers it for the next cell
// ---------------------------------------------------------------------------
`default_nettype none

module lrupr_cell #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
	parameter int CELL_IDX  = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          active,
	input  wire lrupr_pkg::tok_t tok_i,
	input  wire lrupr_pkg::upd_t upd,
	output lrupr_pkg::tok_t    tok_o
);

	localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [RANK_W-1:0]          RANK_TOP = RANK_W'(FRAMES - 1);
	localparam logic [lrupr_pkg::IDX_W-1:0] MY_IDX  = lrupr_pkg::IDX_W'(CELL_IDX);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;

	lrupr_pkg::tok_t                      tok_d;
	lrupr_pkg::tok_t                      tok_q;
	logic [lrupr_pkg::IDX_W-1:0]          rank_ext;
	logic [lrupr_pkg::PAGE_BITS_MAX-1:0]  page_ext;

	assign rank_ext = lrupr_pkg::IDX_W'(rank_q);
	assign page_ext = lrupr_pkg::PAGE_BITS_MAX'(page_q);

	always_comb begin
		tok_d = tok_i;
		if (active) begin
			if (!tok_i.hit && valid_q && (page_ext == tok_i.page)) begin
				tok_d.hit      = 1'b1;
				tok_d.hit_idx  = MY_IDX;
				tok_d.hit_rank = rank_ext;
			end
			if (!tok_i.empty && !valid_q) begin
				tok_d.empty     = 1'b1;
				tok_d.empty_idx = MY_IDX;
			end
			// frame 0 is always active and seeds the victim search
			if ((CELL_IDX == 0) || (rank_ext > tok_i.vic_rank)) begin
				tok_d.vic_idx  = MY_IDX;
				tok_d.vic_rank = rank_ext;
				tok_d.vic_page = page_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.vld) begin
			if (upd.slot == MY_IDX) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (!upd.was_valid || (rank_ext < upd.old_rank))
					&& (rank_q != RANK_TOP)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.vld && upd.fill && (upd.slot == MY_IDX)) begin
			page_q <= upd.page[PAGE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lrupr_ctrl.sv =====
// ---------------------------------------------------------------------------
// lrupr_ctrl
// request intake, frame count register, resolution of the search result,
// rank update broadcast, result register and fault counter
// ---------------------------------------------------------------------------
`default_nettype none

module lrupr_ctrl #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lrupr_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [lrupr_pkg::PAGE_W-1:0]      page,
	output lrupr_pkg::tok_t                        tok_first,
	input  wire lrupr_pkg::tok_t                   tok_last,
	output lrupr_pkg::upd_t                        upd,
	output logic [FRAMES-1:0]                      active,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   hit,
	output logic [lrupr_pkg::FRAME_IDX_W-1:0]      frame_index,
	output logic                                   evicted_valid,
	output logic [lrupr_pkg::PAGE_W-1:0]           evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0]          fault_total
);

	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam logic [lrupr_pkg::PAGE_BITS_MAX-1:0] PAGE_MASK =
		{lrupr_pkg::PAGE_BITS_MAX{1'b1}} >> (lrupr_pkg::PAGE_BITS_MAX - PAGE_BITS);

	lrupr_pkg::state_t state_q, state_d;

	logic [lrupr_pkg::CFG_W-1:0]   frames_in_use_q;
	logic [CNT_W-1:0]              n_active;
	lrupr_pkg::tok_t               tok_first_q;
	lrupr_pkg::tok_t               res_q;
	logic                          accept;
	logic                          fire;
	logic [lrupr_pkg::IDX_W-1:0]   slot;
	logic                          evict;
	logic [lrupr_pkg::FAULT_W-1:0] fault_q;
	logic                          out_valid_q;
	logic                          hit_q;
	logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index_q;
	logic                          evicted_valid_q;
	logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lrupr_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			frames_in_use_q <= cfg_data;
		end
	end

	// zero acts as one, too many acts as all frames
	always_comb begin
		if (frames_in_use_q == '0) begin
			n_active = CNT_W'(1);
		end else if (32'(frames_in_use_q) > 32'(FRAMES)) begin
			n_active = CNT_W'(FRAMES);
		end else begin
			n_active = CNT_W'(frames_in_use_q);
		end
	end

	for (genvar k = 0; k < FRAMES; k++) begin : g_active
		assign active[k] = (CNT_W'(k) < n_active);
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrupr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		fire     = 1'b0;
		in_stall = 1'b1;
		unique case (state_q)
			lrupr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = lrupr_pkg::ST_SCAN;
				end
			end
			lrupr_pkg::ST_SCAN: begin
				if (tok_last.vld) begin
					state_d = lrupr_pkg::ST_DONE;
				end
			end
			lrupr_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					fire    = 1'b1;
					state_d = lrupr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrupr_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && !in_stall;

	// request enters the row at frame 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_first_q <= '0;
		end else begin
			tok_first_q <= '0;
			if (accept) begin
				tok_first_q.vld  <= 1'b1;
				tok_first_q.page <= lrupr_pkg::PAGE_BITS_MAX'(page) & PAGE_MASK;
			end
		end
	end

	assign tok_first = tok_first_q;

	always_ff @(posedge clk) begin
		if ((state_q == lrupr_pkg::ST_SCAN) && tok_last.vld) begin
			res_q <= tok_last;
		end
	end

	// hit, else lowest empty frame, else the least recent one
	always_comb begin
		evict = !res_q.hit && !res_q.empty;
		if (res_q.hit) begin
			slot = res_q.hit_idx;
		end else if (res_q.empty) begin
			slot = res_q.empty_idx;
		end else begin
			slot = res_q.vic_idx;
		end
	end

	always_comb begin
		upd           = '0;
		upd.vld       = fire;
		upd.slot      = slot;
		upd.was_valid = !res_q.empty || res_q.hit;
		upd.old_rank  = res_q.hit ? res_q.hit_rank : res_q.vic_rank;
		upd.fill      = !res_q.hit;
		upd.page      = res_q.page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (fire && !res_q.hit && (fault_q != lrupr_pkg::FAULT_MAX)) begin
			fault_q <= fault_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q           <= res_q.hit;
			frame_index_q   <= slot[lrupr_pkg::FRAME_IDX_W-1:0];
			evicted_valid_q <= evict;
			evicted_page_q  <= evict ? res_q.vic_page[lrupr_pkg::PAGE_W-1:0] : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	// the counter moves only when a result is loaded, so it holds while stalled
	assign fault_total   = fault_q;

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_replacement_core.sv =====
// ---------------------------------------------------------------------------
// lru_page_replacement_core
// fully associative lru page replacement over a row of frame cells
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  cfg       cfg_valid / cfg_ready   cfg_data (frames in use)
//  in        in_valid / in_stall     page
//  out       out_valid / out_stall   hit, frame_index, evicted_valid,
//                                    evicted_page, fault_total
//
//  one request at a time: the lookup walks the row one frame per cycle,
//  ST_SCAN captures it at the row's end, ST_DONE updates ranks and loads the
//  result, and ST_IDLE takes the next request
//  in_stall is high from a taken request until its result is loaded; while
//  a result waits on out_stall the next request walks the row and then waits
//  reset clears valid bits, ranks and the fault count; frames in use is 8
// ---------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_core #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lrupr_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [lrupr_pkg::PAGE_W-1:0]      page,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   hit,
	output logic [lrupr_pkg::FRAME_IDX_W-1:0]      frame_index,
	output logic                                   evicted_valid,
	output logic [lrupr_pkg::PAGE_W-1:0]           evicted_page,
	output logic [lrupr_pkg::FAULT_W-1:0]          fault_total
);

	lrupr_pkg::tok_t     chain [FRAMES+1];
	lrupr_pkg::upd_t     upd;
	logic [FRAMES-1:0]   active;

	lrupr_ctrl #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.page          (page),
		.tok_first     (chain[0]),
		.tok_last      (chain[FRAMES]),
		.upd           (upd),
		.active        (active),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

	for (genvar k = 0; k < FRAMES; k++) begin : g_cell
		lrupr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.CELL_IDX  (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.active (active[k]),
			.tok_i  (chain[k]),
			.upd    (upd),
			.tok_o  (chain[k+1])
		);
	end

endmodule

`default_nettype wire

// ===== rtl/core/lrupr_checker.sv =====
// ---------------------------------------------------------------------------
// lrupr_checker
// port-level checks on the lru page replacement core, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none

`include "lru_page_replacement_core_defines.svh"

module lrupr_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              cfg_valid,
	input wire logic                              cfg_ready,
	input wire logic [lrupr_pkg::CFG_W-1:0]       cfg_data,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic [lrupr_pkg::PAGE_W-1:0]      page,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic                              hit,
	input wire logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index,
	input wire logic                              evicted_valid,
	input wire logic [lrupr_pkg::PAGE_W-1:0]      evicted_page,
	input wire logic [lrupr_pkg::FAULT_W-1:0]     fault_total
);

	// a stalled result stays, counter included
	`LRUPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(fault_total) && $stable(frame_index))

	// a hit never replaces a resident page
	`LRUPR_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted_valid)

	// the replaced page reads zero when nothing was replaced
	`LRUPR_ASSERT_NOW(a_evict_page_zero, out_valid && !evicted_valid, evicted_page == '0)

	// one reference in flight: a taken request closes the input
	`LRUPR_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (.*);

`default_nettype wire
